>>> src/scdd_pkg.sv
// ============================================================================
// scdd_pkg
// Shared sizes, codes and types for the scoped case-value dedup unit.
// ============================================================================
package scdd_pkg;

    localparam int MAX_LEVELS  = 16;
    localparam int MAX_ENTRIES = 1024;

    localparam int VAL_W     = 64;
    localparam int CNT_W     = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVL_CNT_W = $clog2(MAX_LEVELS + 1);
    localparam int ENT_W     = $clog2(MAX_ENTRIES);
    localparam int TOP_W     = $clog2(MAX_ENTRIES + 1);

    localparam logic [MODE_W-1:0] MODE_CASE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEFAULT2 = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_DEEP = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SCOPE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One row of the scope table.
    typedef struct packed {
        logic [TOP_W-1:0] base;
        logic             wide;
        logic [CNT_W-1:0] counter;
    } t_scope;

endpackage

>>> src/scdd_in_if.sv
// ============================================================================
// scdd_in_if
// Input channel: one beat carries a case, default, open or close item.
// ============================================================================
interface scdd_in_if;
    logic                          valid;
    logic                          ready;
    logic [scdd_pkg::MODE_W-1:0]   mode;
    logic signed [scdd_pkg::VAL_W-1:0] value;
    logic                          wide_values;

    modport source (output valid, output mode, output value, output wide_values,
                    input ready);
    modport sink   (input valid, input mode, input value, input wide_values,
                    output ready);
endinterface

>>> src/scdd_out_if.sv
// ============================================================================
// scdd_out_if
// Output channel: one result beat per input item.
// ============================================================================
interface scdd_out_if;
    logic                              valid;
    logic                              ready;
    logic [scdd_pkg::STATUS_W-1:0]     status;
    logic signed [scdd_pkg::VAL_W-1:0] stored_value;
    logic [scdd_pkg::CNT_W-1:0]        case_count;

    modport source (output valid, output status, output stored_value,
                    output case_count, input ready);
    modport sink   (input valid, input status, input stored_value,
                    input case_count, output ready);
endinterface

>>> src/scoped_case_value_dedup_unit.sv
// ============================================================================
// scoped_case_value_dedup_unit
// Scope stack with per-scope duplicate detection of case values.
// ============================================================================
// Sequence: an accepted item is evaluated in S_EVAL and its result beat is
//   registered from S_RESULT; a case item in an open scope also passes
//   S_SCAN while its scope holds unchecked values, stopping at a match, and
//   S_INSERT if none matched. One item at a time; the scan reads the value
//   RAM one entry per cycle, and S_RESULT waits for a free output slot.
// Reset: synchronous, active low; clears the scope count, the store fill
//   count and all default marks. No clearing pass: RAM contents start unknown.
module scoped_case_value_dedup_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scdd_in_if.sink           i_in,
    scdd_out_if.source        o_out
);

    // Sequencer state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    localparam int VW = scdd_pkg::VAL_W;

    // Control state
    logic [2:0]                        r_state, n_state;
    logic [scdd_pkg::LVL_CNT_W-1:0]    r_open, n_open;
    logic [scdd_pkg::TOP_W-1:0]        r_top, n_top;
    logic [scdd_pkg::TOP_W-1:0]        r_ptr, n_ptr;
    logic [scdd_pkg::MAX_LEVELS-1:0]   r_dflt, n_dflt;
    logic                              r_out_valid, n_out_valid;

    // Item and result holding registers
    logic [scdd_pkg::MODE_W-1:0]       r_mode, n_mode;
    logic [VW-1:0]                     r_value, n_value;
    logic                              r_wide, n_wide;
    logic [VW-1:0]                     r_stored, n_stored;
    logic [scdd_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [scdd_pkg::CNT_W-1:0]        r_count, n_count;
    logic [scdd_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [VW-1:0]                     r_out_stored, n_out_stored;
    logic [scdd_pkg::CNT_W-1:0]        r_out_count, n_out_count;

    // RAM ports
    logic                              sc_we;
    logic [scdd_pkg::LVL_W-1:0]        sc_waddr;
    scdd_pkg::t_scope                  sc_wdata;
    scdd_pkg::t_scope                  sc_rdata;
    logic                              vm_we;
    logic [scdd_pkg::ENT_W-1:0]        vm_waddr;
    logic [scdd_pkg::ENT_W-1:0]        vm_raddr;
    logic [VW-1:0]                     vm_rdata;

    // Helpers
    logic [scdd_pkg::LVL_CNT_W-1:0]    w_open_m1;
    logic [scdd_pkg::LVL_W-1:0]        w_lvl;
    logic [scdd_pkg::TOP_W-1:0]        w_ptr_inc;
    logic                              w_accept;
    logic                              w_too_deep;
    logic [VW-1:0]                     w_cut;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_open_m1  = r_open - 1'b1;
    assign w_lvl      = w_open_m1[scdd_pkg::LVL_W-1:0];
    assign w_ptr_inc  = r_ptr + 1'b1;
    assign w_too_deep = (r_open >= scdd_pkg::LVL_CNT_W'(scdd_pkg::MAX_LEVELS));
    // Narrow scopes keep the low word, sign-extended
    assign w_cut      = sc_rdata.wide ? r_value : {{(VW/2){r_value[VW/2-1]}}, r_value[VW/2-1:0]};

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.stored_value = r_out_stored;
    assign o_out.case_count   = r_out_count;

    // Scope row of the innermost level is read every cycle; the row seen in
    // S_EVAL is the one addressed on the accepting cycle.
    scdd_scope_ram u_scope_ram (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_raddr (w_lvl),
        .o_rdata (sc_rdata)
    );

    scdd_value_ram u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vm_we),
        .i_waddr (vm_waddr),
        .i_wdata (r_stored),
        .i_raddr (vm_raddr),
        .o_rdata (vm_rdata)
    );

    // Scan address: first entry of the scope on evaluation, next entry while
    // scanning, so every cycle compares one stored value.
    always_comb begin
        if (r_state == S_EVAL) begin
            vm_raddr = sc_rdata.base[scdd_pkg::ENT_W-1:0];
        end else begin
            vm_raddr = w_ptr_inc[scdd_pkg::ENT_W-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_open       = r_open;
        n_top        = r_top;
        n_ptr        = r_ptr;
        n_dflt       = r_dflt;
        n_out_valid  = r_out_valid;
        n_mode       = r_mode;
        n_value      = r_value;
        n_wide       = r_wide;
        n_stored     = r_stored;
        n_status     = r_status;
        n_count      = r_count;
        n_out_status = r_out_status;
        n_out_stored = r_out_stored;
        n_out_count  = r_out_count;
        sc_we        = 1'b0;
        sc_waddr     = w_lvl;
        sc_wdata     = sc_rdata;
        vm_we        = 1'b0;
        vm_waddr     = r_top[scdd_pkg::ENT_W-1:0];

        // Drop the result beat once taken
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_in.mode;
                    n_value  = i_in.value;
                    n_wide   = i_in.wide_values;
                    n_stored = '0;
                    n_count  = '0;
                    n_status = scdd_pkg::ST_OK;
                    n_state  = S_EVAL;
                end
            end

            S_EVAL: begin
                n_state = S_RESULT;
                if (r_mode == scdd_pkg::MODE_OPEN) begin
                    if (w_too_deep) begin
                        n_status = scdd_pkg::ST_TOO_DEEP;
                    end else begin
                        // Push a fresh scope row at the next level
                        sc_we            = 1'b1;
                        sc_waddr         = r_open[scdd_pkg::LVL_W-1:0];
                        sc_wdata.base    = r_top;
                        sc_wdata.wide    = r_wide;
                        sc_wdata.counter = scdd_pkg::CNT_W'(1);
                        n_dflt[r_open[scdd_pkg::LVL_W-1:0]] = 1'b0;
                        n_open           = r_open + 1'b1;
                    end
                end else if (r_open == '0) begin
                    n_status = scdd_pkg::ST_NO_SCOPE;
                end else begin
                    case (r_mode)
                        scdd_pkg::MODE_CASE: begin
                            // Bump the counter now; the scan cannot undo it
                            sc_we = 1'b1;
                            if (sc_rdata.counter != scdd_pkg::CNT_MAX) begin
                                sc_wdata.counter = sc_rdata.counter + 1'b1;
                            end
                            n_stored = w_cut;
                            n_ptr    = sc_rdata.base;
                            if (sc_rdata.base >= r_top) begin
                                n_state = S_INSERT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        scdd_pkg::MODE_DEFAULT: begin
                            if (r_dflt[w_lvl]) begin
                                n_status = scdd_pkg::ST_DEFAULT2;
                            end else begin
                                n_dflt[w_lvl] = 1'b1;
                            end
                        end
                        default: begin
                            // Close: pop the level and free its entries
                            n_count       = sc_rdata.counter;
                            n_top         = sc_rdata.base;
                            n_dflt[w_lvl] = 1'b0;
                            n_open        = w_open_m1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (vm_rdata == r_stored) begin
                    n_status = scdd_pkg::ST_DUP;
                    n_state  = S_RESULT;
                end else begin
                    n_ptr = w_ptr_inc;
                    if (w_ptr_inc >= r_top) begin
                        n_state = S_INSERT;
                    end
                end
            end

            S_INSERT: begin
                if (r_top >= scdd_pkg::TOP_W'(scdd_pkg::MAX_ENTRIES)) begin
                    n_status = scdd_pkg::ST_FULL;
                end else begin
                    vm_we = 1'b1;
                    n_top = r_top + 1'b1;
                end
                n_state = S_RESULT;
            end

            S_RESULT: begin
                // Hold until the output slot is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_stored = r_stored;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_top       <= '0;
            r_ptr       <= '0;
            r_dflt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_top       <= n_top;
            r_ptr       <= n_ptr;
            r_dflt      <= n_dflt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_wide       <= n_wide;
        r_stored     <= n_stored;
        r_status     <= n_status;
        r_count      <= n_count;
        r_out_status <= n_out_status;
        r_out_stored <= n_out_stored;
        r_out_count  <= n_out_count;
    end

`ifndef SYNTH
    // An accepted beat always starts evaluation
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted item did not enter evaluation");

    // Fill count never passes the store depth
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= scdd_pkg::TOP_W'(scdd_pkg::MAX_ENTRIES))
        else $error("store fill count out of range");

    // Scope count never passes the level limit
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= scdd_pkg::LVL_CNT_W'(scdd_pkg::MAX_LEVELS))
        else $error("open scope count out of range");

    // The scan pointer stays inside the used part of the store
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr < r_top))
        else $error("scan pointer beyond store top");
`endif

endmodule

>>> src/scdd_value_ram.sv
// ============================================================================
// scdd_value_ram
// Case value store: one write port, one read port, registered read data.
// ============================================================================
module scdd_value_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [scdd_pkg::ENT_W-1:0]   i_waddr,
    input  logic [scdd_pkg::VAL_W-1:0]   i_wdata,
    input  logic [scdd_pkg::ENT_W-1:0]   i_raddr,
    output logic [scdd_pkg::VAL_W-1:0]   o_rdata
);

    logic [scdd_pkg::VAL_W-1:0] r_mem [scdd_pkg::MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/scdd_scope_ram.sv
// ============================================================================
// scdd_scope_ram
// Scope table: base, width flag and case counter per nesting level.
// ============================================================================
module scdd_scope_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [scdd_pkg::LVL_W-1:0] i_waddr,
    input  scdd_pkg::t_scope           i_wdata,
    input  logic [scdd_pkg::LVL_W-1:0] i_raddr,
    output scdd_pkg::t_scope           o_rdata
);

    scdd_pkg::t_scope r_mem [scdd_pkg::MAX_LEVELS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
